FILE: rtl/rmct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmct_pkg
// Shared widths, constants, sequencer states and the node ordering function.
// ---------------------------------------------------------------------------
package rmct_pkg;

  localparam int VAL_W  = 20;
  localparam int TAG_W  = 10;
  localparam int NODE_W = VAL_W + TAG_W;
  localparam int KEY_W  = NODE_W + 1;

  localparam logic [VAL_W-1:0] EMPTY_LIMIT = VAL_W'(1000000);
  localparam logic [VAL_W:0]   EMPTY_KEY   = {(VAL_W+1){1'b1}};

  // Word commands on in_cmd.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QLOOP,
    S_QLWAIT,
    S_QRCHK,
    S_QRWAIT,
    S_QPICK,
    S_DREAD,
    S_DWAIT,
    S_EMIT,
    S_UPWR,
    S_UPCALC
  } state_t;

  // Empty nodes sort above every loaded value; ties break on tag.
  function automatic key_t node_key(input node_t n);
    logic [VAL_W-1:0] v;
    logic [VAL_W:0]   k;
    v = n[NODE_W-1:TAG_W];
    k = (v == '0) ? EMPTY_KEY : {1'b0, v};
    return {k, n[TAG_W-1:0]};
  endfunction

endpackage

FILE: rtl/range_min_consume_tree_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_min_consume_tree_top
// Range-minimum segment tree with consume-on-query, held in one node RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (in_*) carry either a load (in_cmd = 0: write in_position
//   with in_load_value / in_load_tag) or a query (in_cmd = 1: find the least
//   (value, tag) pair over in_range_low..in_range_high, report it, then
//   subtract in_amount from it). A load yields no output word; a query
//   yields exactly one on out_*.
//   Words move when valid is high and stall is low on the same edge.
//   One word is in work at a time; in_stall is high while it is.
//   Work per word: a load walks the path to the root, writing each node
//   and reading its sibling at every level. A query runs the bottom-up
//   range search (up to two RAM reads per level), a descent to the
//   leftmost matching leaf and the path rebuild. Every step is bounded
//   by the single read port.
//   The result sits in an output register; the next word is accepted
//   while it waits, and the sequencer only holds if a second result is
//   ready before the first has left.
//   Reset clears the sequencer and the output valid; the RAM is not
//   cleared, so every position must be loaded before the first query.
// ---------------------------------------------------------------------------
module range_min_consume_tree_top #(
  parameter int ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [9:0]  in_position,
  input  logic [19:0] in_load_value,
  input  logic [9:0]  in_load_tag,
  input  logic [9:0]  in_range_low,
  input  logic [9:0]  in_range_high,
  input  logic [19:0] in_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [9:0]  out_winner_tag,
  output logic [19:0] out_winner_value
);

  localparam int NW = $clog2(2 * ENTRIES);
  localparam int LW = NW + 1;

  rmct_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]         l_r, l_nxt, r_r, r_nxt;
  logic [NW-1:0]         idx_r, idx_nxt;
  logic [NW-1:0]         lidx_r, lidx_nxt, ridx_r, ridx_nxt;
  rmct_pkg::node_t       lbest_r, lbest_nxt, rbest_r, rbest_nxt;
  rmct_pkg::node_t       cur_r, cur_nxt;
  logic [19:0]           amt_r, amt_nxt;
  logic                  res_found_r, res_found_nxt;
  logic                  do_upd_r, do_upd_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [9:0]            out_tag_r, out_tag_nxt;
  logic [19:0]           out_val_r, out_val_nxt;

  logic                  mem_we;
  logic [NW-1:0]         mem_waddr, mem_raddr;
  rmct_pkg::node_t       mem_wdata, mem_rdata;

  // Load and query set-up arithmetic, done in 32 bits then narrowed.
  logic [31:0]           hi32, lo32, pos32;
  logic [19:0]           ld_val;
  logic [19:0]           win_val;
  rmct_pkg::node_t       parent;

  rmct_ram #(.WIDTH(rmct_pkg::NODE_W), .DEPTH(2 * ENTRIES)) u_nodes (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmct_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    idx_r       <= idx_nxt;
    lidx_r      <= lidx_nxt;
    ridx_r      <= ridx_nxt;
    lbest_r     <= lbest_nxt;
    rbest_r     <= rbest_nxt;
    cur_r       <= cur_nxt;
    amt_r       <= amt_nxt;
    res_found_r <= res_found_nxt;
    do_upd_r    <= do_upd_nxt;
    out_found_r <= out_found_nxt;
    out_tag_r   <= out_tag_nxt;
    out_val_r   <= out_val_nxt;
  end

  always_comb begin
    hi32    = (32'(in_range_high) >= 32'(ENTRIES)) ? 32'(ENTRIES - 1) : 32'(in_range_high);
    lo32    = 32'(in_range_low);
    pos32   = 32'(in_position);
    ld_val  = (in_load_value >= rmct_pkg::EMPTY_LIMIT) ? '0 : in_load_value;
    win_val = cur_r[rmct_pkg::NODE_W-1:rmct_pkg::TAG_W];
    // Parent from current node and its sibling; left child wins ties.
    if (idx_r[0] == 1'b0) begin
      parent = (rmct_pkg::node_key(mem_rdata) < rmct_pkg::node_key(cur_r)) ? mem_rdata : cur_r;
    end else begin
      parent = (rmct_pkg::node_key(cur_r) < rmct_pkg::node_key(mem_rdata)) ? cur_r : mem_rdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    idx_nxt       = idx_r;
    lidx_nxt      = lidx_r;
    ridx_nxt      = ridx_r;
    lbest_nxt     = lbest_r;
    rbest_nxt     = rbest_r;
    cur_nxt       = cur_r;
    amt_nxt       = amt_r;
    res_found_nxt = res_found_r;
    do_upd_nxt    = do_upd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_tag_nxt   = out_tag_r;
    out_val_nxt   = out_val_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = cur_r;
    mem_raddr     = idx_r;

    unique case (state_r)
      rmct_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == rmct_pkg::CMD_LOAD) begin
            // Load: drop positions beyond the array, else rebuild the path.
            if (pos32 < 32'(ENTRIES)) begin
              idx_nxt   = NW'(pos32 + 32'(ENTRIES));
              cur_nxt   = {ld_val, in_load_tag};
              state_nxt = rmct_pkg::S_UPWR;
            end
          end else begin
            amt_nxt   = in_amount;
            lbest_nxt = '0;
            rbest_nxt = '0;
            lidx_nxt  = '0;
            ridx_nxt  = '0;
            l_nxt     = LW'(lo32 + 32'(ENTRIES));
            r_nxt     = LW'(hi32 + 32'(ENTRIES) + 32'd1);
            if (lo32 > hi32) begin
              res_found_nxt = 1'b0;
              do_upd_nxt    = 1'b0;
              state_nxt     = rmct_pkg::S_EMIT;
            end else begin
              state_nxt = rmct_pkg::S_QLOOP;
            end
          end
        end
      end
      rmct_pkg::S_QLOOP: begin
        if (!(l_r < r_r)) begin
          state_nxt = rmct_pkg::S_QPICK;
        end else if (l_r[0]) begin
          mem_raddr = NW'(l_r);
          state_nxt = rmct_pkg::S_QLWAIT;
        end else begin
          state_nxt = rmct_pkg::S_QRCHK;
        end
      end
      rmct_pkg::S_QLWAIT: begin
        // Left side runs left to right: keep the earlier node on a tie.
        if (rmct_pkg::node_key(mem_rdata) < rmct_pkg::node_key(lbest_r)) begin
          lbest_nxt = mem_rdata;
          lidx_nxt  = NW'(l_r);
        end
        l_nxt     = l_r + LW'(1);
        state_nxt = rmct_pkg::S_QRCHK;
      end
      rmct_pkg::S_QRCHK: begin
        if (r_r[0]) begin
          r_nxt     = r_r - LW'(1);
          mem_raddr = NW'(r_r - LW'(1));
          state_nxt = rmct_pkg::S_QRWAIT;
        end else begin
          l_nxt     = l_r >> 1;
          r_nxt     = r_r >> 1;
          state_nxt = rmct_pkg::S_QLOOP;
        end
      end
      rmct_pkg::S_QRWAIT: begin
        // Right side runs right to left: take the newer node on a tie.
        if (rmct_pkg::node_key(mem_rdata) <= rmct_pkg::node_key(rbest_r)) begin
          rbest_nxt = mem_rdata;
          ridx_nxt  = NW'(r_r);
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = rmct_pkg::S_QLOOP;
      end
      rmct_pkg::S_QPICK: begin
        if (rmct_pkg::node_key(rbest_r) < rmct_pkg::node_key(lbest_r)) begin
          cur_nxt = rbest_r;
          idx_nxt = ridx_r;
        end else begin
          cur_nxt = lbest_r;
          idx_nxt = lidx_r;
        end
        if (cur_nxt[rmct_pkg::NODE_W-1:rmct_pkg::TAG_W] == '0) begin
          res_found_nxt = 1'b0;
          do_upd_nxt    = 1'b0;
          state_nxt     = rmct_pkg::S_EMIT;
        end else begin
          state_nxt = rmct_pkg::S_DREAD;
        end
      end
      rmct_pkg::S_DREAD: begin
        if (32'(idx_r) >= 32'(ENTRIES)) begin
          res_found_nxt = 1'b1;
          do_upd_nxt    = 1'b1;
          state_nxt     = rmct_pkg::S_EMIT;
        end else begin
          mem_raddr = {idx_r[NW-2:0], 1'b0};
          state_nxt = rmct_pkg::S_DWAIT;
        end
      end
      rmct_pkg::S_DWAIT: begin
        // Descend left whenever the left child holds the winning pair.
        idx_nxt   = {idx_r[NW-2:0], (mem_rdata == cur_r) ? 1'b0 : 1'b1};
        state_nxt = rmct_pkg::S_DREAD;
      end
      rmct_pkg::S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_tag_nxt   = res_found_r ? cur_r[rmct_pkg::TAG_W-1:0] : '0;
          out_val_nxt   = res_found_r ? win_val : '0;
          if (do_upd_r) begin
            cur_nxt   = {(amt_r >= win_val) ? 20'd0 : (win_val - amt_r),
                         cur_r[rmct_pkg::TAG_W-1:0]};
            state_nxt = rmct_pkg::S_UPWR;
          end else begin
            state_nxt = rmct_pkg::S_IDLE;
          end
        end
      end
      rmct_pkg::S_UPWR: begin
        mem_we    = 1'b1;
        mem_raddr = idx_r ^ NW'(1);
        state_nxt = (idx_r == NW'(1)) ? rmct_pkg::S_IDLE : rmct_pkg::S_UPCALC;
      end
      rmct_pkg::S_UPCALC: begin
        cur_nxt   = parent;
        idx_nxt   = idx_r >> 1;
        state_nxt = rmct_pkg::S_UPWR;
      end
      default: begin
        state_nxt = rmct_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall         = (state_r != rmct_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_winner_tag   = out_tag_r;
  assign out_winner_value = out_val_r;

endmodule

FILE: rtl/rmct_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmct_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rmct_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rmct_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmct_checker
// Port-level checks on the range-minimum tree, bound to the top level.
// ---------------------------------------------------------------------------
module rmct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [9:0]  out_winner_tag,
  input logic [19:0] out_winner_value
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted word did not occupy the sequencer");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_winner_tag == 10'd0 && out_winner_value == 20'd0)
    else $error("not-found word carries data");

  a_found_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_winner_value != 20'd0 && out_winner_value < 20'd1000000)
    else $error("found word carries an empty value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

endmodule

bind range_min_consume_tree_top rmct_checker u_rmct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_winner_tag   (out_winner_tag),
  .out_winner_value (out_winner_value)
);

FILE: sim/range_min_consume_tree_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_min_consume_tree_top_test
// Self-checking bench for the consuming range-minimum tree. Every position
// is filled first. A table of directed words then covers ties, empties, the
// value limit and inverted ranges. A long random run follows. A behavioural
// copy of the position store predicts each query answer that the table does
// not give directly; answers are compared in order as they leave the block.
// ---------------------------------------------------------------------------
module range_min_consume_tree_top_test;

  localparam int POSITIONS   = 1024;
  localparam int RANDOM_WORDS = 860;
  localparam int DIR_ROWS     = 21;
  localparam bit CMD_LOAD  = rmct_pkg::CMD_LOAD;
  localparam bit CMD_QUERY = rmct_pkg::CMD_QUERY;
  localparam logic [19:0] FILL_VALUE = 20'd900000;

  typedef struct packed {
    logic        found;
    logic [9:0]  tag;
    logic [19:0] value;
  } answer_t;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  pos;
    logic [19:0] lval;
    logic [9:0]  ltag;
    logic [9:0]  lo;
    logic [9:0]  hi;
    logic [19:0] amt;
    logic        typed;   // answer below is read off directly
    answer_t     ans;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [9:0]  in_position = '0;
  logic [19:0] in_load_value = '0;
  logic [9:0]  in_load_tag = '0;
  logic [9:0]  in_range_low = '0;
  logic [9:0]  in_range_high = '0;
  logic [19:0] in_amount = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [9:0]  out_winner_tag;
  logic [19:0] out_winner_value;

  // Behavioural copy of the position store; value 0 means empty.
  logic [19:0] pool_val [POSITIONS];
  logic [9:0]  pool_tag [POSITIONS];
  answer_t     pending_answers [$];
  int          fails = 0;
  bit          calm = 1'b0;   // suppress idling on both sides

  range_min_consume_tree_top dut (.*);

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("range_min_consume_tree_top test failed");
    $finish;
  end

  // Ordering key: empty entries sort above every loaded value, ties on tag.
  function automatic logic [30:0] order_key(input logic [19:0] v, input logic [9:0] t);
    return {(v == '0) ? 21'h1FFFFF : {1'b0, v}, t};
  endfunction

  function automatic void store_load(input logic [9:0] p, input logic [19:0] v,
                                     input logic [9:0] t);
    pool_val[p] = (v >= rmct_pkg::EMPTY_LIMIT) ? 20'd0 : v;
    pool_tag[p] = t;
  endfunction

  // Find the least pair in range (leftmost on equal pairs), report it and
  // consume the amount from it.
  function automatic answer_t take_min_and_consume(input logic [9:0] lo,
                                                   input logic [9:0] hi,
                                                   input logic [19:0] amt);
    answer_t     a;
    int          best_p;
    logic [30:0] best_k;
    logic [30:0] k;
    a = '0;
    best_p = -1;
    best_k = {21'h1FFFFF, 10'd0};
    for (int p = lo; p <= hi; p++) begin
      k = order_key(pool_val[p], pool_tag[p]);
      if (k < best_k) begin
        best_k = k;
        best_p = p;
      end
    end
    if (best_p >= 0 && pool_val[best_p] != '0) begin
      a.found = 1'b1;
      a.tag   = pool_tag[best_p];
      a.value = pool_val[best_p];
      pool_val[best_p] = (amt >= a.value) ? 20'd0 : a.value - amt;
    end
    return a;
  endfunction

  // Drive one word at the falling edge and hold it until it is taken.
  task automatic send_word(input step_t s);
    answer_t predicted;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_cmd        = s.cmd;
    in_position   = s.pos;
    in_load_value = s.lval;
    in_load_tag   = s.ltag;
    in_range_low  = s.lo;
    in_range_high = s.hi;
    in_amount     = s.amt;
    do @(posedge clk); while (in_stall);
    if (s.cmd == CMD_LOAD) begin
      store_load(s.pos, s.lval, s.ltag);
    end else begin
      predicted = take_min_and_consume(s.lo, s.hi, s.amt);
      pending_answers = {pending_answers, (s.typed ? s.ans : predicted)};
    end
    @(negedge clk);
  endtask

  // Receiver stall: occasional, none during the calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  // Compare each answer leaving the block with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer found=%0d tag=%0d value=%0d", $time,
                 out_found, out_winner_tag, out_winner_value);
        fails++;
      end else begin
        want = pending_answers.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, out_found);
          fails++;
        end
        if (out_winner_tag !== want.tag) begin
          $display("%0t: winner_tag expected %0d actual %0d", $time, want.tag,
                   out_winner_tag);
          fails++;
        end
        if (out_winner_value !== want.value) begin
          $display("%0t: winner_value expected %0d actual %0d", $time, want.value,
                   out_winner_value);
          fails++;
        end
      end
    end
  end

  // Directed words after the fill; every untouched position holds 900000
  // with its own index as tag.
  step_t dir_steps [0:DIR_ROWS-1] = '{
    // ties broken on tag, then amount zero leaves the value alone
    '{CMD_LOAD, 10'd0, 20'd1, 10'd1023, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_LOAD, 10'd1, 20'd1, 10'd0, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1, 20'd0, 1'b1, '{1'b1, 10'd0, 20'd1}},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1, 20'd1, 1'b1, '{1'b1, 10'd0, 20'd1}},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1, 20'd5, 1'b1, '{1'b1, 10'd1023, 20'd1}},
    // both emptied: nothing found
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1, 20'd0, 1'b1, answer_t'(0)},
    // inverted range
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd5, 10'd3, 20'd3, 1'b1, answer_t'(0)},
    // value limit: 999999 holds, 1000000 and above, and zero, are empty
    '{CMD_LOAD, 10'd1023, 20'd999999, 10'd5, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_LOAD, 10'd1022, 20'd1000000, 10'd7, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_LOAD, 10'd1021, 20'hFFFFF, 10'd9, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_LOAD, 10'd1020, 20'd0, 10'd1, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd1020, 10'd1023, 20'hFFFFF, 1'b1,
      '{1'b1, 10'd5, 20'd999999}},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd1020, 10'd1023, 20'd0, 1'b1, answer_t'(0)},
    // equal pairs: the leftmost is consumed
    '{CMD_LOAD, 10'd10, 20'd7, 10'd3, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_LOAD, 10'd12, 20'd7, 10'd3, 10'd0, 10'd0, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd10, 10'd12, 20'd2, 1'b1, '{1'b1, 10'd3, 20'd7}},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd10, 10'd12, 20'd0, 1'b1, '{1'b1, 10'd3, 20'd5}},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd11, 10'd12, 20'd7, 1'b0, answer_t'(0)},
    // whole array, then a single position
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1023, 20'd0, 1'b0, answer_t'(0)},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd1023, 20'hFFFFF, 1'b0, answer_t'(0)},
    '{CMD_QUERY, 10'd0, 20'd0, 10'd0, 10'd0, 10'd0, 20'd0, 1'b1, answer_t'(0)}
  };

  function automatic step_t random_word();
    step_t s;
    int    pick;
    s = '0;
    s.cmd  = 1'($urandom_range(0, 1));
    s.pos  = 10'($urandom_range(0, POSITIONS - 1));
    s.ltag = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 3))
                                          : 10'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 60)      s.lval = 20'($urandom_range(1, 40));
    else if (pick < 75) s.lval = 20'($urandom_range(0, 20'hFFFFF));
    else if (pick < 85) s.lval = '0;
    else                s.lval = 20'($urandom_range(999990, 1000010));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      s.lo = 10'($urandom_range(0, POSITIONS - 1));
      s.hi = (int'(s.lo) + 40 > POSITIONS - 1) ? 10'(POSITIONS - 1)
                                               : 10'(s.lo + $urandom_range(0, 40));
    end else if (pick < 70) begin
      s.lo = 10'($urandom_range(0, POSITIONS - 1));
      s.hi = 10'($urandom_range(0, POSITIONS - 1));
    end else if (pick < 90) begin
      s.lo = '0;
      s.hi = 10'(POSITIONS - 1);
    end else begin
      s.lo = 10'($urandom_range(0, POSITIONS - 1));
      s.hi = s.lo;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40)      s.amt = 20'($urandom_range(0, 20));
    else if (pick < 70) s.amt = '0;
    else                s.amt = 20'($urandom_range(0, 20'hFFFFF));
    return s;
  endfunction

  initial begin
    step_t s;
    // Hold reset low at the start, once.
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Fill every position so that no query reads an unwritten entry.
    for (int p = 0; p < POSITIONS; p++) begin
      s = '0;
      s.cmd  = CMD_LOAD;
      s.pos  = 10'(p);
      s.lval = FILL_VALUE;
      s.ltag = 10'(p);
      send_word(s);
    end

    // Walk the directed table.
    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_steps[i]);

    // Hold the sender until every answer has drained.
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= 300 && i < 450);
      send_word(random_word());
    end
    calm = 1'b0;
    in_valid = 1'b0;

    // Drain, then allow the path rebuild of the last query to finish.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("range_min_consume_tree_top test passed");
    end else begin
      $display("range_min_consume_tree_top test failed");
    end
    $finish;
  end

endmodule
